/* src/sem_pkg.sv */
// shared types, constants and codes of the sobel edge magnitude block
`timescale 1ns / 1ps

package sem_pkg;

   localparam int MAX_WIDTH   = 2048;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int WIDTH_REG_W = 12;
   localparam int ROW_W       = 16;
   localparam int PIXEL_W     = 8;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int GRAD_W      = 12;
   localparam int ABS_W       = 10;
   localparam int SUM_W       = 2 * ABS_W + 1;
   localparam int ROOT_W      = 8;
   localparam int ROOT_IDX_W  = $clog2(ROOT_W);

   localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = WIDTH_REG_W'(640);
   localparam logic [ROW_W-1:0]       HEIGHT_RESET = ROW_W'(480);
   localparam logic [WIDTH_REG_W-1:0] WIDTH_MIN   = WIDTH_REG_W'(3);
   localparam logic [WIDTH_REG_W-1:0] WIDTH_MAX   = WIDTH_REG_W'(MAX_WIDTH);
   localparam logic [ROW_W-1:0]       HEIGHT_MIN  = ROW_W'(3);

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               frame_start;
   } req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] edge_value;
      logic [COL_W-1:0]   center_col;
      logic [ROW_W-1:0]   center_row;
      logic               frame_last;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOCATE,
      S_UPDATE,
      S_GRAD,
      S_SQUARE,
      S_ROOT,
      S_OUTPUT
   } state_type;

   typedef struct packed {
      logic accept;
      logic locate;
      logic update;
      logic grad;
      logic square;
      logic root_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic root_last;
      logic out_free;
   } status_type;

endpackage

/* src/sem_ram.sv */
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module sem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/sem_ctrl.sv */
// controller state machine sequencing one pixel through the datapath
`timescale 1ns / 1ps

module sem_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  sem_pkg::status_type status,
   output sem_pkg::cmd_type    cmd
);

   import sem_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_LOCATE;
            end
         end
         S_LOCATE: begin
            cmd.locate = 1'b1;
            state_in   = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.emit ? S_GRAD : S_IDLE;
         end
         S_GRAD: begin
            cmd.grad = 1'b1;
            state_in = S_SQUARE;
         end
         S_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = S_ROOT;
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            if (status.root_last) begin
               state_in = S_OUTPUT;
            end
         end
         S_OUTPUT: begin
            // hold until the output beat slot is free
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

/* src/sem_datapath.sv */
// line stores, window, counters, gradient, square root and output register
`timescale 1ns / 1ps

module sem_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  sem_pkg::req_type                  req_data,
   output sem_pkg::rsp_type                  rsp_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic                              csr_wr_en,
   input  logic [sem_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sem_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  sem_pkg::cmd_type                  cmd,
   output sem_pkg::status_type               status
);

   import sem_pkg::*;

   // configuration
   logic [WIDTH_REG_W-1:0] width_ff;
   logic [ROW_W-1:0]       height_ff;
   logic [WIDTH_REG_W-1:0] w_eff;
   logic [ROW_W-1:0]       h_eff;

   // position
   logic [COL_W-1:0]       col_ff, col_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [COL_W-1:0]       x_ff;
   logic [ROW_W-1:0]       y_ff;
   logic [COL_W-1:0]       x_in;
   logic [ROW_W-1:0]       y_in;
   logic                   emit_ff;
   logic                   last_ff;

   logic [PIXEL_W-1:0]     px_ff;
   logic                   fs_ff;

   logic [PIXEL_W-1:0]     up1;
   logic [PIXEL_W-1:0]     up2;
   logic [PIXEL_W-1:0]     win_ff [3][3];

   logic [ABS_W-1:0]       ax_ff, ay_ff;
   logic [SUM_W-1:0]       sum_ff;
   logic [ROOT_W-1:0]      root_ff;
   logic [ROOT_IDX_W-1:0]  bit_idx_ff;

   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  width_ff  <= csr_wdata[WIDTH_REG_W-1:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_wdata[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      w_eff = width_ff;
      if (width_ff < WIDTH_MIN) begin
         w_eff = WIDTH_MIN;
      end else if (width_ff > WIDTH_MAX) begin
         w_eff = WIDTH_MAX;
      end
      h_eff = (height_ff < HEIGHT_MIN) ? HEIGHT_MIN : height_ff;
   end

   // position of this pixel and counters for the next one
   logic [COL_W-1:0]       c0;
   logic [ROW_W-1:0]       r0;
   logic [WIDTH_REG_W-1:0] cn;
   logic [ROW_W:0]         rn;

   always_comb begin
      c0 = fs_ff ? '0 : col_ff;
      r0 = fs_ff ? '0 : row_ff;
      x_in = c0;
      y_in = r0;
      if ({1'b0, c0} >= w_eff) begin
         x_in = '0;
         y_in = r0 + ROW_W'(1);
      end
      if (y_in >= h_eff) begin
         y_in = '0;
      end
      cn     = {1'b0, x_in} + WIDTH_REG_W'(1);
      rn     = {1'b0, y_in} + (ROW_W+1)'(1);
      col_in = cn[COL_W-1:0];
      row_in = y_in;
      if (cn >= w_eff) begin
         col_in = '0;
         row_in = (rn >= {1'b0, h_eff}) ? '0 : rn[ROW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.locate) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         px_ff <= req_data.pixel;
         fs_ff <= req_data.frame_start;
      end
      if (cmd.locate) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         emit_ff <= (y_in >= ROW_W'(2)) && (x_in >= COL_W'(2));
         last_ff <= (y_in == h_eff - ROW_W'(1)) && ({1'b0, x_in} == w_eff - WIDTH_REG_W'(1));
      end
   end

   // line store a holds the row above, line store b the row two above
   sem_ram #(
      .WIDTH(PIXEL_W),
      .DEPTH(MAX_WIDTH)
   ) u_store_a (
      .clock  (clock),
      .wr_en  (cmd.update),
      .wr_addr(x_ff),
      .wr_data(px_ff),
      .rd_en  (cmd.locate),
      .rd_addr(x_in),
      .rd_data(up1)
   );

   sem_ram #(
      .WIDTH(PIXEL_W),
      .DEPTH(MAX_WIDTH)
   ) u_store_b (
      .clock  (clock),
      .wr_en  (cmd.update),
      .wr_addr(x_ff),
      .wr_data(up1),
      .rd_en  (cmd.locate),
      .rd_addr(x_in),
      .rd_data(up2)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (cmd.update) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= up2;
         win_ff[1][2] <= up1;
         win_ff[2][2] <= px_ff;
      end
   end

   // sobel gradients on the updated window
   logic signed [GRAD_W-1:0] gx, gy;
   logic signed [GRAD_W-1:0] p00, p01, p02, p10, p12, p20, p21, p22;
   logic [GRAD_W-1:0]        gx_abs, gy_abs;

   always_comb begin
      p00 = GRAD_W'(win_ff[0][0]);
      p01 = GRAD_W'(win_ff[0][1]);
      p02 = GRAD_W'(win_ff[0][2]);
      p10 = GRAD_W'(win_ff[1][0]);
      p12 = GRAD_W'(win_ff[1][2]);
      p20 = GRAD_W'(win_ff[2][0]);
      p21 = GRAD_W'(win_ff[2][1]);
      p22 = GRAD_W'(win_ff[2][2]);
      gx = (p02 + (p12 <<< 1) + p22) - (p00 + (p10 <<< 1) + p20);
      gy = (p20 + (p21 <<< 1) + p22) - (p00 + (p01 <<< 1) + p02);
      gx_abs = gx[GRAD_W-1] ? GRAD_W'(-gx) : GRAD_W'(gx);
      gy_abs = gy[GRAD_W-1] ? GRAD_W'(-gy) : GRAD_W'(gy);
   end

   // one result bit per cycle; sums of 65536 and up settle at all ones
   logic [ROOT_W-1:0]   trial;
   logic [2*ROOT_W-1:0] trial_sq;

   always_comb begin
      trial    = root_ff | (ROOT_W'(1) << bit_idx_ff);
      trial_sq = trial * trial;
   end

   always_ff @(posedge clock) begin
      if (cmd.grad) begin
         ax_ff <= gx_abs[ABS_W-1:0];
         ay_ff <= gy_abs[ABS_W-1:0];
      end
      if (cmd.square) begin
         sum_ff     <= SUM_W'(ax_ff * ax_ff) + SUM_W'(ay_ff * ay_ff);
         root_ff    <= '0;
         bit_idx_ff <= ROOT_IDX_W'(ROOT_W - 1);
      end else if (cmd.root_step) begin
         if (SUM_W'(trial_sq) <= sum_ff) begin
            root_ff <= trial;
         end
         bit_idx_ff <= bit_idx_ff - ROOT_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff.edge_value <= root_ff;
         rsp_data_ff.center_col <= x_ff - COL_W'(1);
         rsp_data_ff.center_row <= y_ff - ROW_W'(1);
         rsp_data_ff.frame_last <= last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_data_ff;
   assign status.emit      = emit_ff;
   assign status.root_last = (bit_idx_ff == '0);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

endmodule

/* src/sobel_edge_magnitude.sv */
// top level of the streaming 3x3 sobel gradient magnitude block
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_ready     req_data  (pixel, frame_start)
//   rsp      out        rsp_valid / rsp_ready     rsp_data  (edge_value, center_col,
//                                                            center_row, frame_last)
//   csr      in         csr_wr_en                 csr_index, csr_wdata
//
// a pixel without a result steps through accept, line store read and window update;
// one with a result adds gradient, square, a root at one bit a cycle, then output load.
// reset is synchronous: counters and window clear, width 640 and height 480;
// line stores are not cleared and need no sweep.
// a result waits in the output register while the next pixel is taken; the
// block stalls in its final step only if that register is still full.
`timescale 1ns / 1ps

module sobel_edge_magnitude (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  sem_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output sem_pkg::rsp_type                rsp_data,
   input  logic                            csr_wr_en,
   input  logic [sem_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sem_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import sem_pkg::*;

   cmd_type    cmd;
   status_type status;

   sem_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   sem_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cmd      (cmd),
      .status   (status)
   );

endmodule

/* dv/sem_edge_checker.sv */
// checker for the sobel edge magnitude block: mirrors the pixel stream and compares results
`timescale 1ns / 1ps

module sem_edge_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  sem_pkg::req_type                req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  sem_pkg::rsp_type                rsp_data,
   input  logic                            csr_wr_en,
   input  logic [sem_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sem_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              expect_pending,
   output int                              mismatch_count,
   output int                              results_checked
);
   import sem_pkg::*;

   logic [PIXEL_W-1:0]     prev_row  [MAX_WIDTH];   // row y-1
   logic [PIXEL_W-1:0]     prev_row2 [MAX_WIDTH];   // row y-2
   logic [PIXEL_W-1:0]     window [3][3];
   int unsigned            col_pos;
   int unsigned            row_pos;
   logic [WIDTH_REG_W-1:0] width_reg;
   logic [ROW_W-1:0]       height_reg;
   rsp_type                expected_edges [$];
   rsp_type                oldest_edge;
   int                     fill_idx;

   // floor square root, saturated to the 8-bit range
   function automatic logic [PIXEL_W-1:0] gradient_magnitude(int gx, int gy);
      int sum_sq;
      int root;
      sum_sq = gx * gx + gy * gy;
      if (sum_sq >= 65536)
         return 8'hFF;
      root = 0;
      while ((root + 1) * (root + 1) <= sum_sq)
         root++;
      return PIXEL_W'(root);
   endfunction

   task automatic take_pixel(input req_type beat);
      int unsigned        eff_w;
      int unsigned        eff_h;
      int unsigned        x;
      int unsigned        y;
      int                 r;
      int                 gx;
      int                 gy;
      logic [PIXEL_W-1:0] above;
      logic [PIXEL_W-1:0] above2;
      rsp_type            edge_exp;
      eff_w = width_reg;
      if (eff_w < 3)
         eff_w = 3;
      if (eff_w > MAX_WIDTH)
         eff_w = MAX_WIDTH;
      eff_h = height_reg;
      if (eff_h < 3)
         eff_h = 3;

      if (beat.frame_start) begin
         col_pos = 0;
         row_pos = 0;
      end
      // counters can sit past a size that was lowered
      if (col_pos >= eff_w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= eff_h)
         row_pos = 0;
      x = col_pos;
      y = row_pos;

      above  = prev_row[x];
      above2 = prev_row2[x];
      prev_row2[x] = above;
      prev_row[x]  = beat.pixel;
      for (r = 0; r < 3; r++) begin
         window[r][0] = window[r][1];
         window[r][1] = window[r][2];
      end
      window[0][2] = above2;
      window[1][2] = above;
      window[2][2] = beat.pixel;

      if (y >= 2 && x >= 2) begin
         gx = (int'(window[0][2]) + 2 * int'(window[1][2]) + int'(window[2][2]))
            - (int'(window[0][0]) + 2 * int'(window[1][0]) + int'(window[2][0]));
         gy = (int'(window[2][0]) + 2 * int'(window[2][1]) + int'(window[2][2]))
            - (int'(window[0][0]) + 2 * int'(window[0][1]) + int'(window[0][2]));
         edge_exp.edge_value = gradient_magnitude(gx, gy);
         edge_exp.center_col = COL_W'(x - 1);
         edge_exp.center_row = ROW_W'(y - 1);
         edge_exp.frame_last = (y == eff_h - 1) && (x == eff_w - 1);
         expected_edges.push_back(edge_exp);
      end

      col_pos = x + 1;
      if (col_pos >= eff_w) begin
         col_pos = 0;
         row_pos = y + 1;
         if (row_pos >= eff_h)
            row_pos = 0;
      end
   endtask

   task automatic check_field(input string field, input logic [ROW_W-1:0] exp_v,
                              input logic [ROW_W-1:0] got_v);
      if (got_v !== exp_v) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (fill_idx = 0; fill_idx < MAX_WIDTH; fill_idx++) begin
            prev_row[fill_idx]  = '0;
            prev_row2[fill_idx] = '0;
         end
         for (fill_idx = 0; fill_idx < 9; fill_idx++)
            window[fill_idx / 3][fill_idx % 3] = '0;
         col_pos    = 0;
         row_pos    = 0;
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         expected_edges.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (expected_edges.size() == 0) begin
               mismatch_count++;
               $display("%0t: result with none expected: edge %0d col %0d row %0d last %0d",
                        $time, rsp_data.edge_value, rsp_data.center_col,
                        rsp_data.center_row, rsp_data.frame_last);
            end else begin
               oldest_edge = expected_edges.pop_front();
               check_field("edge_value", ROW_W'(oldest_edge.edge_value),
                           ROW_W'(rsp_data.edge_value));
               check_field("center_col", ROW_W'(oldest_edge.center_col),
                           ROW_W'(rsp_data.center_col));
               check_field("center_row", oldest_edge.center_row, rsp_data.center_row);
               check_field("frame_last", ROW_W'(oldest_edge.frame_last),
                           ROW_W'(rsp_data.frame_last));
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               REG_IMAGE_WIDTH: begin
                  width_reg = csr_wdata[WIDTH_REG_W-1:0];
               end
               REG_IMAGE_HEIGHT: begin
                  height_reg = csr_wdata[ROW_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready)
            take_pixel(req_data);
      end
      expect_pending = expected_edges.size();
   end

endmodule

/* dv/tb_sobel_edge_magnitude.sv */
// testbench top for the sobel edge magnitude block: clock, reset, pixel stimulus and verdict
`timescale 1ns / 1ps

module tb_sobel_edge_magnitude;
   import sem_pkg::*;

   localparam int CLOCK_HALF    = 4;
   localparam int RESET_CYCLES  = 5;
   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 400000;

   typedef enum int {
      SHADE_ANY,
      SHADE_DIM,
      SHADE_BINARY
   } shade_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int send_idle_pct  = 0;
   int stall_pct      = 0;
   int hold_token     = 0;
   int hold_seen      = 0;
   int hold_left      = 0;
   int cycle_count    = 0;
   int pixels_sent    = 0;
   int sizes_run      = 0;
   int last_eff_width = 0;
   int expect_pending;
   int mismatch_count;
   int results_checked;
   int r;
   int c;

   sobel_edge_magnitude u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sem_edge_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .expect_pending  (expect_pending),
      .mismatch_count  (mismatch_count),
      .results_checked (results_checked)
   );

   always #CLOCK_HALF clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expect_pending);
         $display("FAIL");
         $finish;
      end
   end

   // result side: random stalls, plus a long hold whenever the token moves
   always @(negedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic logic [PIXEL_W-1:0] shade(input shade_type style);
      case (style)
         SHADE_DIM:    return PIXEL_W'($urandom_range(7));
         SHADE_BINARY: return ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
         default:      return PIXEL_W'($urandom);
      endcase
   endfunction

   task automatic push_pixel(input logic [PIXEL_W-1:0] value, input logic starts_frame);
      req_type beat;
      beat.pixel       = value;
      beat.frame_start = starts_frame;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      pixels_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expect_pending != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(input logic [WIDTH_REG_W-1:0] width_val,
                            input logic [ROW_W-1:0] height_val, input int budget,
                            input bit pause_midway);
      int        eff_w;
      int        eff_h;
      int        frame_len;
      int        left;
      int        pos;
      bit        fresh;
      bit        first;
      shade_type style;
      eff_w = width_val;
      if (eff_w < 3)
         eff_w = 3;
      if (eff_w > MAX_WIDTH)
         eff_w = MAX_WIDTH;
      eff_h = height_val;
      if (eff_h < 3)
         eff_h = 3;
      write_reg(REG_IMAGE_WIDTH, CSR_DATA_W'(width_val));
      write_reg(REG_IMAGE_HEIGHT, CSR_DATA_W'(height_val));
      // wider rows would read line store columns never filled, so restart the frame
      fresh = (eff_w > last_eff_width) || ($urandom_range(1) == 1);
      last_eff_width = eff_w;
      sizes_run++;
      left  = budget;
      first = 1'b1;
      while (left > 0) begin
         frame_len = eff_w * eff_h;
         if (frame_len <= 64 && $urandom_range(7) == 0)
            frame_len = $urandom_range(frame_len, 1);   // frame cut short
         style = shade_type'($urandom_range(2));
         for (pos = 0; pos < frame_len && left > 0; pos++) begin
            push_pixel(shade(style), (pos == 0) && (fresh || !first));
            left--;
            if (pause_midway && left == budget / 2)
               wait_drained();
         end
         first = 1'b0;
      end
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // directed: 3x3 frames from sizes below the minimum
      write_reg(REG_IMAGE_WIDTH, CSR_DATA_W'(1));
      write_reg(REG_IMAGE_HEIGHT, CSR_DATA_W'(0));
      last_eff_width = 3;
      sizes_run++;
      for (r = 0; r < 3; r++)
         for (c = 0; c < 3; c++)
            push_pixel((c == 2) ? 8'hFF : 8'h00, r == 0 && c == 0);
      push_pixel(8'h5A, 1'b0);   // stray pixel, cut off by the frame start below
      for (r = 0; r < 3; r++)
         for (c = 0; c < 3; c++)
            push_pixel((r == 0) ? 8'hFF : 8'h00, r == 0 && c == 0);
      // no frame start here: the row counter wraps on its own
      for (r = 0; r < 3; r++)
         for (c = 0; c < 3; c++)
            push_pixel((r == 0 && c == 2) ? 8'd10 : 8'd0, 1'b0);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);

      // width above the maximum acts as the full line store
      run_phase(12'hFFF, 16'd3, 60, 1'b0);
      run_phase(12'd7, 16'd5, 60, 1'b0);

      send_idle_pct = 75;
      run_phase(12'd2, 16'd2, 70, 1'b1);
      run_phase(12'd10, 16'hFFFF, 70, 1'b0);

      send_idle_pct = 0;
      stall_pct     = 75;
      run_phase(12'd6, 16'd4, 80, 1'b0);
      run_phase(12'd4, 16'd1, 60, 1'b0);

      send_idle_pct = 16;
      stall_pct     = 16;
      run_phase(WIDTH_REG_W'($urandom_range(12, 3)), ROW_W'($urandom_range(8)), 80, 1'b0);
      run_phase(WIDTH_REG_W'($urandom_range(16)), ROW_W'($urandom_range(8)), 80, 1'b0);

      // output held off for a long stretch while pixels keep coming
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_token++;
      run_phase(12'd9, 16'd6, 90, 1'b0);

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("run covered %0d pixels and %0d edge results over %0d frame sizes",
               pixels_sent, results_checked, sizes_run);
      $display("widths 3..2048 and heights 3..65535 incl. clamped values, idle/stall mixes");
      if (mismatch_count == 0 && expect_pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
